### src/pwfm_pkg.sv
`timescale 1ns / 1ps

package pwfm_pkg;

  // Default saturation width of every value; the ports stay 32 bits wide.
  localparam int DATA_WIDTH_DEF = 32;

  // Width of the product and accumulator path.
  localparam int WIDE_W = 68;

  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_LIM   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_THR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIM   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIM   = 3'd7;

  // Controller modes.
  localparam logic [1:0] MODE_PLAIN    = 2'd0;
  localparam logic [1:0] MODE_DFILT    = 2'd1;
  localparam logic [1:0] MODE_EFILT    = 2'd2;

  // Input kinds.
  localparam logic KIND_STEP  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef logic signed [31:0]       val_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [31:0]       coef_t;

  // Filter taps in Q2.30, ordered as the multiply sequence runs:
  // x, x[n-1], x[n-2], y[n-1], y[n-2]. The feedback taps are stored negated
  // so that every term is simply accumulated.
  localparam coef_t LPF_DIV_C [0:4] = '{
    32'sd72429549, 32'sd144859098, 32'sd72429549,
    32'sd1227265970, -32'sd443242341
  };
  localparam coef_t LPF_ERR_C [0:4] = '{
    32'sd1014355, 32'sd2028710, 32'sd1014355,
    32'sd2052132225, -32'sd982447822
  };

  typedef struct packed {
    logic [1:0]  mode;
    logic        err_clamp;
    logic        separate;
    logic        int_clamp;
    logic [31:0] gain_p;
    logic [31:0] gain_i;
    logic [31:0] gain_d;
    logic [30:0] err_lim;
    logic [30:0] sep_thr;
    logic [30:0] int_lim;
    logic [30:0] out_lim;
  } cfg_t;

  // Command to the shared multiply-accumulate unit.
  typedef struct packed {
    logic issue;     // start a product this cycle
    logic clr;       // this product starts a new sum
    logic filt_rnd;  // read the sum rounded from Q2.30 products, else Q8.24
  } mac_cmd_t;

  function automatic int sat_width(input int dw);
    sat_width = (dw < 16) ? 16 : ((dw > 32) ? 32 : dw);
  endfunction

  function automatic val_t val_max(input int dw);
    val_max = val_t'((longint'(1) <<< (sat_width(dw) - 1)) - longint'(1));
  endfunction

  function automatic val_t val_min(input int dw);
    val_min = val_t'(-(longint'(1) <<< (sat_width(dw) - 1)));
  endfunction

  function automatic val_t sat_val(input wide_t x, input val_t vmax, input val_t vmin);
    if (x > wide_t'(vmax)) begin
      sat_val = vmax;
    end else if (x < wide_t'(vmin)) begin
      sat_val = vmin;
    end else begin
      sat_val = x[31:0];
    end
  endfunction

  function automatic val_t clamp_sym(input val_t x, input logic [30:0] lim);
    val_t lim_s;
    val_t r;
    lim_s = val_t'({1'b0, lim});
    r = x;
    if (r >= lim_s) begin
      r = lim_s;
    end
    if (r <= -lim_s) begin
      r = -lim_s;
    end
    clamp_sym = r;
  endfunction

endpackage

### src/pwfm_mac.sv
`timescale 1ns / 1ps

// Shared multiply-accumulate unit. A product is registered in prod_r after
// issue and then added into the sum register acc_r, from which the rounded,
// saturated result is read.
module pwfm_mac #(
  parameter int DATA_WIDTH = pwfm_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pwfm_pkg::mac_cmd_t cmd,
  input  logic signed [32:0] op_a,
  input  logic signed [31:0] op_b,
  output pwfm_pkg::val_t     result
);

  localparam pwfm_pkg::val_t VMAX = pwfm_pkg::val_max(DATA_WIDTH);
  localparam pwfm_pkg::val_t VMIN = pwfm_pkg::val_min(DATA_WIDTH);

  localparam pwfm_pkg::wide_t HALF_Q24 = pwfm_pkg::wide_t'(longint'(1) <<< 23);
  localparam pwfm_pkg::wide_t HALF_Q30 = pwfm_pkg::wide_t'(longint'(1) <<< 29);

  logic signed [32:0] b_ext;
  logic signed [65:0] prod;
  logic signed [65:0] prod_r;
  logic               vld_d_r;
  logic               clr_d_r;
  pwfm_pkg::wide_t    acc_r;
  pwfm_pkg::wide_t    rnd_sum;
  pwfm_pkg::wide_t    shifted;

  assign b_ext = {op_b[31], op_b};
  assign prod  = op_a * b_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= 1'b0;
      clr_d_r <= 1'b0;
    end else begin
      vld_d_r <= cmd.issue;
      clr_d_r <= cmd.clr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      prod_r <= prod;
    end
    if (vld_d_r) begin
      acc_r <= (clr_d_r ? '0 : acc_r) + pwfm_pkg::wide_t'(prod_r);
    end
  end

  // Round half up, then saturate to the value width.
  always_comb begin
    rnd_sum = acc_r + (cmd.filt_rnd ? HALF_Q30 : HALF_Q24);
    shifted = cmd.filt_rnd ? (rnd_sum >>> 30) : (rnd_sum >>> 24);
    result  = pwfm_pkg::sat_val(shifted, VMAX, VMIN);
  end

endmodule

### src/pwfm_ctrl.sv
`timescale 1ns / 1ps

// Step sequencer and controller state. All products go through the shared
// multiply-accumulate unit; sums, clamps and saturations are done here.
module pwfm_ctrl #(
  parameter int DATA_WIDTH = pwfm_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pwfm_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  pwfm_pkg::val_t     in_setpoint,
  input  pwfm_pkg::val_t     in_measured,
  output logic               out_valid,
  input  logic               out_ready,
  output pwfm_pkg::val_t     out_drive,
  output pwfm_pkg::mac_cmd_t mac_cmd,
  output logic signed [32:0] mac_a,
  output logic signed [31:0] mac_b,
  input  pwfm_pkg::val_t     mac_y
);

  localparam pwfm_pkg::val_t VMAX = pwfm_pkg::val_max(DATA_WIDTH);
  localparam pwfm_pkg::val_t VMIN = pwfm_pkg::val_min(DATA_WIDTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ERR   = 4'd1;
  localparam logic [3:0] S_PREP  = 4'd2;
  localparam logic [3:0] S_FILT  = 4'd3;
  localparam logic [3:0] S_FWAIT = 4'd4;
  localparam logic [3:0] S_FDONE = 4'd5;
  localparam logic [3:0] S_GI    = 4'd6;
  localparam logic [3:0] S_GP    = 4'd7;
  localparam logic [3:0] S_GD    = 4'd8;
  localparam logic [3:0] S_RP    = 4'd9;
  localparam logic [3:0] S_RD    = 4'd10;
  localparam logic [3:0] S_CLAMP = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  localparam logic [2:0] TAP_LAST = 3'd4;

  logic [3:0] state_r, state_nxt;
  logic [2:0] tap_r, tap_nxt;

  pwfm_pkg::val_t sp_r, sp_nxt;
  pwfm_pkg::val_t meas_r, meas_nxt;
  pwfm_pkg::val_t e_r, e_nxt;
  pwfm_pkg::val_t x_r, x_nxt;
  pwfm_pkg::val_t dterm_r, dterm_nxt;
  pwfm_pkg::val_t pterm_r, pterm_nxt;
  pwfm_pkg::val_t drive_r, drive_nxt;

  pwfm_pkg::val_t prev_err_r, prev_err_nxt;
  pwfm_pkg::val_t integ_r, integ_nxt;
  pwfm_pkg::val_t last_drive_r, last_drive_nxt;
  pwfm_pkg::val_t fin0_r, fin0_nxt;
  pwfm_pkg::val_t fin1_r, fin1_nxt;
  pwfm_pkg::val_t fout0_r, fout0_nxt;
  pwfm_pkg::val_t fout1_r, fout1_nxt;
  pwfm_pkg::val_t prev_fe_r, prev_fe_nxt;

  logic           is_dfilt;
  logic           is_efilt;
  pwfm_pkg::val_t ec;
  pwfm_pkg::val_t fc;
  pwfm_pkg::val_t isum;
  pwfm_pkg::val_t ival;
  logic [32:0]    mag;
  logic           gate;
  pwfm_pkg::coef_t coef;

  assign is_dfilt = (cfg.mode == pwfm_pkg::MODE_DFILT);
  assign is_efilt = (cfg.mode == pwfm_pkg::MODE_EFILT);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_drive = drive_r;

  always_comb begin
    coef = is_efilt ? pwfm_pkg::LPF_ERR_C[tap_r] : pwfm_pkg::LPF_DIV_C[tap_r];
    ec   = pwfm_pkg::clamp_sym(e_r, cfg.err_lim);
    fc   = pwfm_pkg::clamp_sym(mac_y, cfg.err_lim);
    mag  = e_r[31] ? (33'd0 - {e_r[31], e_r}) : {1'b0, e_r};
    gate = !cfg.separate || (mag <= {2'b00, cfg.sep_thr});
    isum = pwfm_pkg::sat_val(pwfm_pkg::wide_t'(integ_r) + pwfm_pkg::wide_t'(mac_y),
                             VMAX, VMIN);
    ival = gate ? isum : integ_r;
    if (cfg.int_clamp) begin
      ival = pwfm_pkg::clamp_sym(ival, cfg.int_lim);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    tap_nxt        = tap_r;
    sp_nxt         = sp_r;
    meas_nxt       = meas_r;
    e_nxt          = e_r;
    x_nxt          = x_r;
    dterm_nxt      = dterm_r;
    pterm_nxt      = pterm_r;
    drive_nxt      = drive_r;
    prev_err_nxt   = prev_err_r;
    integ_nxt      = integ_r;
    last_drive_nxt = last_drive_r;
    fin0_nxt       = fin0_r;
    fin1_nxt       = fin1_r;
    fout0_nxt      = fout0_r;
    fout1_nxt      = fout1_r;
    prev_fe_nxt    = prev_fe_r;
    mac_cmd        = '0;
    mac_a          = '0;
    mac_b          = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == pwfm_pkg::KIND_CLEAR) begin
            integ_nxt = '0;
            drive_nxt = last_drive_r;
            state_nxt = S_OUT;
          end else begin
            sp_nxt    = in_setpoint;
            meas_nxt  = in_measured;
            state_nxt = S_ERR;
          end
        end
      end
      S_ERR: begin
        e_nxt = pwfm_pkg::sat_val(pwfm_pkg::wide_t'(sp_r) - pwfm_pkg::wide_t'(meas_r),
                                  VMAX, VMIN);
        state_nxt = S_PREP;
      end
      S_PREP: begin
        tap_nxt = '0;
        if (is_dfilt) begin
          x_nxt = pwfm_pkg::sat_val(pwfm_pkg::wide_t'(e_r) - pwfm_pkg::wide_t'(prev_err_r),
                                    VMAX, VMIN);
          state_nxt = S_FILT;
        end else if (is_efilt) begin
          x_nxt     = e_r;
          state_nxt = S_FILT;
        end else begin
          // Plain mode, which also covers the unused mode code.
          if (cfg.err_clamp) begin
            e_nxt = ec;
          end
          dterm_nxt = pwfm_pkg::sat_val(pwfm_pkg::wide_t'(e_nxt) -
                                        pwfm_pkg::wide_t'(prev_err_r), VMAX, VMIN);
          prev_err_nxt = e_nxt;
          state_nxt    = S_GI;
        end
      end
      S_FILT: begin
        mac_cmd.issue = 1'b1;
        mac_cmd.clr   = (tap_r == '0);
        mac_a         = {coef[31], coef};
        case (tap_r)
          3'd0:    mac_b = x_r;
          3'd1:    mac_b = fin1_r;
          3'd2:    mac_b = fin0_r;
          3'd3:    mac_b = fout1_r;
          3'd4:    mac_b = fout0_r;
          default: mac_b = x_r;
        endcase
        tap_nxt = tap_r + 3'd1;
        if (tap_r == TAP_LAST) begin
          state_nxt = S_FWAIT;
        end
      end
      S_FWAIT: begin
        state_nxt = S_FDONE;
      end
      S_FDONE: begin
        mac_cmd.filt_rnd = 1'b1;
        fin0_nxt  = fin1_r;
        fin1_nxt  = x_r;
        fout0_nxt = fout1_r;
        fout1_nxt = mac_y;
        if (is_efilt) begin
          prev_err_nxt = e_r;
          dterm_nxt = pwfm_pkg::sat_val(pwfm_pkg::wide_t'(mac_y) -
                                        pwfm_pkg::wide_t'(prev_fe_r), VMAX, VMIN);
          e_nxt       = cfg.err_clamp ? fc : mac_y;
          prev_fe_nxt = e_nxt;
        end else begin
          dterm_nxt    = mac_y;
          e_nxt        = cfg.err_clamp ? ec : e_r;
          prev_err_nxt = e_nxt;
        end
        state_nxt = S_GI;
      end
      S_GI: begin
        mac_cmd.issue = 1'b1;
        mac_cmd.clr   = 1'b1;
        mac_a         = {1'b0, cfg.gain_i};
        mac_b         = e_r;
        state_nxt     = S_GP;
      end
      S_GP: begin
        mac_cmd.issue = 1'b1;
        mac_cmd.clr   = 1'b1;
        mac_a         = {1'b0, cfg.gain_p};
        mac_b         = e_r;
        state_nxt     = S_GD;
      end
      S_GD: begin
        // The integral product is ready in this cycle.
        mac_cmd.issue = 1'b1;
        mac_cmd.clr   = 1'b1;
        mac_a         = {1'b0, cfg.gain_d};
        mac_b         = dterm_r;
        integ_nxt     = ival;
        state_nxt     = S_RP;
      end
      S_RP: begin
        pterm_nxt = mac_y;
        state_nxt = S_RD;
      end
      S_RD: begin
        drive_nxt = pwfm_pkg::sat_val(pwfm_pkg::wide_t'(pterm_r) +
                                      pwfm_pkg::wide_t'(integ_r) +
                                      pwfm_pkg::wide_t'(mac_y), VMAX, VMIN);
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        drive_nxt      = pwfm_pkg::clamp_sym(drive_r, cfg.out_lim);
        last_drive_nxt = drive_nxt;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tap_r        <= '0;
      prev_err_r   <= '0;
      integ_r      <= '0;
      last_drive_r <= '0;
      fin0_r       <= '0;
      fin1_r       <= '0;
      fout0_r      <= '0;
      fout1_r      <= '0;
      prev_fe_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      tap_r        <= tap_nxt;
      prev_err_r   <= prev_err_nxt;
      integ_r      <= integ_nxt;
      last_drive_r <= last_drive_nxt;
      fin0_r       <= fin0_nxt;
      fin1_r       <= fin1_nxt;
      fout0_r      <= fout0_nxt;
      fout1_r      <= fout1_nxt;
      prev_fe_r    <= prev_fe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sp_r    <= sp_nxt;
    meas_r  <= meas_nxt;
    e_r     <= e_nxt;
    x_r     <= x_nxt;
    dterm_r <= dterm_nxt;
    pterm_r <= pterm_nxt;
    drive_r <= drive_nxt;
  end

endmodule

### src/pid_with_filtered_modes_top.sv
`timescale 1ns / 1ps

// Positional PID controller with plain, derivative-filtered and
// error-filtered modes, all values signed Q16.16.
// Input stream (in_*): one beat per item. in_tuser is the kind (0 control
// step, 1 clear the integral); in_tdata carries setpoint and measurement.
// Result stream (out_*): exactly one beat per input beat, carrying the clamped
// drive. A clear beat returns the last drive without running a step.
// Configuration (cfg_*): one register write per beat, index and data; the
// port is always ready, and writes are meant to happen while the block idles.
// Timing: one item at a time. A control step is longer in the filtered modes
// than in plain mode, set by the single shared multiplier that runs the five
// filter taps and the three gain products in turn. A clear beat gives its
// result in the cycle after accept. in_tready drops after accept and returns
// in the cycle after the result beat is taken.
// A stalled receiver holds the result in its output register and the block
// takes no new input until that beat is taken.
// Reset (rst_n, synchronous, active low) clears the configuration, the state and
// the controller history to zero; the block is ready in the next cycle.
module pid_with_filtered_modes_top #(
  parameter int DATA_WIDTH = pwfm_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [63:0]                    in_tdata,   // [31:0] setpoint, [63:32] measured
  input  logic [0:0]                     in_tuser,   // [0] kind
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // [31:0] drive
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pwfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  pwfm_pkg::cfg_t     cfg_r;
  pwfm_pkg::mac_cmd_t mac_cmd;
  logic signed [32:0] mac_a;
  logic signed [31:0] mac_b;
  pwfm_pkg::val_t     mac_y;
  pwfm_pkg::val_t     drive;

  assign cfg_ready = 1'b1;

  // Register file. Every index of the port width names a register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pwfm_pkg::REG_CONTROL: begin
          cfg_r.mode      <= cfg_data[1:0];
          cfg_r.err_clamp <= cfg_data[2];
          cfg_r.separate  <= cfg_data[3];
          cfg_r.int_clamp <= cfg_data[4];
        end
        pwfm_pkg::REG_GAIN_P:  cfg_r.gain_p  <= cfg_data;
        pwfm_pkg::REG_GAIN_I:  cfg_r.gain_i  <= cfg_data;
        pwfm_pkg::REG_GAIN_D:  cfg_r.gain_d  <= cfg_data;
        pwfm_pkg::REG_ERR_LIM: cfg_r.err_lim <= cfg_data[30:0];
        pwfm_pkg::REG_SEP_THR: cfg_r.sep_thr <= cfg_data[30:0];
        pwfm_pkg::REG_INT_LIM: cfg_r.int_lim <= cfg_data[30:0];
        pwfm_pkg::REG_OUT_LIM: cfg_r.out_lim <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  pwfm_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser[0]),
    .in_setpoint(in_tdata[31:0]),
    .in_measured(in_tdata[63:32]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_drive  (drive),
    .mac_cmd    (mac_cmd),
    .mac_a      (mac_a),
    .mac_b      (mac_b),
    .mac_y      (mac_y)
  );

  pwfm_mac #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mac_cmd),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .result(mac_y)
  );

  assign out_tdata = drive;

endmodule
